// ===== sv/tpsd_pkg.sv =====
package tpsd_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int Q_WIDTH     = 24;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int TAG_W  = 6;
    localparam int TOL_W  = Q_WIDTH - 1;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 3;

    localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_SUB   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd3;

    localparam logic [STAT_W-1:0] ST_LOADED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOMATCH  = 3'd3;
    localparam logic [STAT_W-1:0] ST_SURVIVOR = 3'd4;
    localparam logic [STAT_W-1:0] ST_NONE     = 3'd5;
    localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd6;

    typedef struct packed {
        logic signed [Q_WIDTH-1:0] x;
        logic signed [Q_WIDTH-1:0] y;
        logic signed [Q_WIDTH-1:0] z;
    } qvec_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        qvec_t             wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

// ===== sv/tpsd_req_if.sv =====
interface tpsd_req_if
    import tpsd_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic signed [Q_WIDTH-1:0] q_x;
    logic signed [Q_WIDTH-1:0] q_y;
    logic signed [Q_WIDTH-1:0] q_z;

    modport source (output valid, func, q_x, q_y, q_z, input ready);
    modport sink   (input valid, func, q_x, q_y, q_z, output ready);
endinterface

// ===== sv/tpsd_rsp_if.sv =====
interface tpsd_rsp_if
    import tpsd_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [STAT_W-1:0]         status;
    logic [TAG_W-1:0]          tag;
    logic signed [Q_WIDTH-1:0] out_x;
    logic signed [Q_WIDTH-1:0] out_y;
    logic signed [Q_WIDTH-1:0] out_z;
    logic                      last;

    modport source (output valid, status, tag, out_x, out_y, out_z, last, input ready);
    modport sink   (input valid, status, tag, out_x, out_y, out_z, last, output ready);
endinterface

// ===== sv/tpsd_cfg_if.sv =====
interface tpsd_cfg_if
    import tpsd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [TOL_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== sv/tpsd_store.sv =====
module tpsd_store
    import tpsd_pkg::*;
(
    input  logic     clk,
    input  mem_req_t mem_req,
    output qvec_t    rdata
);

    qvec_t mem [TABLE_DEPTH];
    qvec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_req.re)
        begin
            rdata_reg <= mem[mem_req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tpsd_cmp.sv =====
module tpsd_cmp
    import tpsd_pkg::*;
(
    input  qvec_t            key,
    input  qvec_t            entry,
    input  logic [TOL_W-1:0] tol,
    output logic             ok
);

    function automatic logic near(input logic signed [Q_WIDTH-1:0] a,
                                  input logic signed [Q_WIDTH-1:0] b,
                                  input logic [TOL_W-1:0] t);
        logic signed [Q_WIDTH:0] d;
        logic        [Q_WIDTH:0] mag;
        begin
            d   = {a[Q_WIDTH-1], a} - {b[Q_WIDTH-1], b};
            mag = d[Q_WIDTH] ? (Q_WIDTH+1)'(-d) : d;
            near = (mag <= {2'b00, t});
        end
    endfunction

    assign ok = near(key.x, entry.x, tol) && near(key.y, entry.y, tol)
             && near(key.z, entry.z, tol);

endmodule

// ===== sv/tpsd_seq.sv =====
module tpsd_seq
    import tpsd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    tpsd_req_if.sink          req,
    tpsd_rsp_if.source        rsp,
    input  logic [TOL_W-1:0]  tol,
    output mem_req_t          mem_req,
    input  qvec_t             rdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [FUNC_W-1:0]      op_reg, op_next;
    qvec_t                  key_reg, key_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [TABLE_DEPTH-1:0] live_reg, live_next;
    logic [CNT_W-1:0]       addr_reg, addr_next;
    logic                   v1_reg, v1_next;
    logic [ADDR_W-1:0]      tag1_reg, tag1_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [STAT_W-1:0]      pend_status_reg, pend_status_next;
    logic [ADDR_W-1:0]      pend_tag_reg, pend_tag_next;
    qvec_t                  pend_q_reg, pend_q_next;
    logic                   out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]      out_status_reg, out_status_next;
    logic [TAG_W-1:0]       out_tag_reg, out_tag_next;
    qvec_t                  out_q_reg, out_q_next;
    logic                   out_last_reg, out_last_next;

    logic match_ok;
    logic out_free;
    logic stall;
    logic stop;
    logic issue;
    logic hit;

    tpsd_cmp u_cmp (
        .key   (key_reg),
        .entry (rdata),
        .tol   (tol),
        .ok    (match_ok)
    );

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign hit       = live_reg[tag1_reg];

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.tag    = out_tag_reg;
    assign rsp.out_x  = out_q_reg.x;
    assign rsp.out_y  = out_q_reg.y;
    assign rsp.out_z  = out_q_reg.z;
    assign rsp.last   = out_last_reg;

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        fill_next        = fill_reg;
        live_next        = live_reg;
        addr_next        = addr_reg;
        v1_next          = v1_reg;
        tag1_next        = tag1_reg;
        pend_valid_next  = pend_valid_reg;
        pend_status_next = pend_status_reg;
        pend_tag_next    = pend_tag_reg;
        pend_q_next      = pend_q_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_tag_next     = out_tag_reg;
        out_q_next       = out_q_reg;
        out_last_next    = out_last_reg;

        mem_req.we       = 1'b0;
        mem_req.waddr    = fill_reg[ADDR_W-1:0];
        mem_req.wdata.x  = req.q_x;
        mem_req.wdata.y  = req.q_y;
        mem_req.wdata.z  = req.q_z;
        mem_req.re       = 1'b0;
        mem_req.raddr    = addr_reg[ADDR_W-1:0];

        stall = 1'b0;
        stop  = 1'b0;
        issue = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    key_next.x = req.q_x;
                    key_next.y = req.q_y;
                    key_next.z = req.q_z;
                    op_next    = req.func;
                    case (req.func)
                        FN_LOAD:
                        begin
                            if (fill_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                pend_status_next = ST_FULL;
                                pend_tag_next    = '0;
                                pend_q_next      = '0;
                            end
                            else
                            begin
                                mem_req.we                     = 1'b1;
                                live_next[fill_reg[ADDR_W-1:0]] = 1'b1;
                                pend_status_next = ST_LOADED;
                                pend_tag_next    = fill_reg[ADDR_W-1:0];
                                pend_q_next      = mem_req.wdata;
                                fill_next        = fill_reg + CNT_W'(1);
                            end
                            state_next = S_FIN;
                        end
                        FN_SUB, FN_READ:
                        begin
                            addr_next       = '0;
                            v1_next         = 1'b0;
                            pend_valid_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        default:
                        begin
                            live_next        = '0;
                            fill_next        = '0;
                            pend_status_next = ST_CLEARED;
                            pend_tag_next    = '0;
                            pend_q_next      = '0;
                            state_next       = S_FIN;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // evaluate the entry whose read came back this cycle
                if (v1_reg)
                begin
                    if (op_reg == FN_SUB)
                    begin
                        if (hit && match_ok)
                        begin
                            live_next[tag1_reg] = 1'b0;
                            pend_status_next    = ST_REMOVED;
                            pend_tag_next       = tag1_reg;
                            pend_q_next         = rdata;
                            v1_next             = 1'b0;
                            state_next          = S_FIN;
                            stop                = 1'b1;
                        end
                    end
                    else if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            if (out_free)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = pend_status_reg;
                                out_tag_next    = TAG_W'(pend_tag_reg);
                                out_q_next      = pend_q_reg;
                                out_last_next   = 1'b0;
                            end
                            else
                            begin
                                stall = 1'b1;
                            end
                        end
                        if (!stall)
                        begin
                            pend_valid_next  = 1'b1;
                            pend_status_next = ST_SURVIVOR;
                            pend_tag_next    = tag1_reg;
                            pend_q_next      = rdata;
                        end
                    end
                end

                if (!stall && !stop)
                begin
                    issue      = (addr_reg < fill_reg);
                    mem_req.re = issue;
                    v1_next    = issue;
                    tag1_next  = addr_reg[ADDR_W-1:0];
                    if (issue)
                    begin
                        addr_next = addr_reg + CNT_W'(1);
                    end
                    else if (!v1_reg)
                    begin
                        // scan finished: settle the closing result
                        state_next = S_FIN;
                        if (op_reg == FN_SUB)
                        begin
                            pend_status_next = ST_NOMATCH;
                            pend_tag_next    = '0;
                            pend_q_next      = '0;
                        end
                        else if (!pend_valid_reg)
                        begin
                            pend_status_next = ST_NONE;
                            pend_tag_next    = '0;
                            pend_q_next      = '0;
                        end
                    end
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_tag_next    = TAG_W'(pend_tag_reg);
                    out_q_next      = pend_q_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            live_reg       <= '0;
            v1_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            live_reg       <= live_next;
            v1_reg         <= v1_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        key_reg         <= key_next;
        addr_reg        <= addr_next;
        tag1_reg        <= tag1_next;
        pend_status_reg <= pend_status_next;
        pend_tag_reg    <= pend_tag_next;
        pend_q_reg      <= pend_q_next;
        out_status_reg  <= out_status_next;
        out_tag_reg     <= out_tag_next;
        out_q_reg       <= out_q_next;
        out_last_reg    <= out_last_next;
    end

endmodule

// ===== sv/tolerant_peak_set_difference.sv =====
// Tolerant peak set difference. Load first-set peaks (func 0), then send
// second-set peaks (func 1): each removes the earliest live stored peak whose
// x, y and z each lie within the tolerance register, reporting the removed
// entry or "no match". Read-out (func 2) emits every surviving entry in load
// order, last beat marked; clear (func 3) empties the table. A subtract ends
// its scan at the first match. The stored peaks sit in a single-read-port
// memory that is scanned one entry per cycle, except while a read-out
// survivor waits on a stalled result channel, through one shared
// three-component compare unit. No new beat is taken until the current
// item's final result has been handed to the output register.
module tolerant_peak_set_difference
    import tpsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tpsd_req_if.sink   req,
    tpsd_rsp_if.source rsp,
    tpsd_cfg_if.sink   cfg
);

    logic [TOL_W-1:0] tol_reg;
    mem_req_t         mem_req;
    qvec_t            rdata;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (cfg.valid)
        begin
            tol_reg <= cfg.data;
        end
    end

    tpsd_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    tpsd_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .tol     (tol_reg),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tpsd_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
    localparam int REPORT_LIMIT = 10;

    localparam logic signed [Q_WIDTH-1:0] Q_MAX   = {1'b0, {(Q_WIDTH-1){1'b1}}};
    localparam logic signed [Q_WIDTH-1:0] Q_MIN   = {1'b1, {(Q_WIDTH-1){1'b0}}};
    localparam logic [TOL_W-1:0]          TOL_MAX = '1;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TAG_W-1:0]  tag;
        qvec_t             q;
        logic              last;
    } peak_result_t;

    logic clk;
    logic rst_n;

    tpsd_req_if req_ch ();
    tpsd_rsp_if rsp_ch ();
    tpsd_cfg_if cfg_ch ();

    tolerant_peak_set_difference i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow of the peak table and the tolerance register
    qvec_t            table_q [TABLE_DEPTH];
    bit               table_live [TABLE_DEPTH];
    int               table_fill;
    logic [TOL_W-1:0] tol_now;

    peak_result_t awaited_reports [$];
    peak_result_t seen_report;

    int cycle_count     = 0;
    int mismatch_count  = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int removals        = 0;
    int full_drops      = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic qvec_t peak(input logic signed [Q_WIDTH-1:0] x,
                                   input logic signed [Q_WIDTH-1:0] y,
                                   input logic signed [Q_WIDTH-1:0] z);
        qvec_t q;
        q.x = x;
        q.y = y;
        q.z = z;
        return q;
    endfunction

    function automatic bit close_enough(input logic signed [Q_WIDTH-1:0] a,
                                        input logic signed [Q_WIDTH-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        return d <= longint'(tol_now);
    endfunction

    task automatic predict_peak_op(input logic [FUNC_W-1:0] f, input qvec_t q);
        peak_result_t r;
        int           n_live;
        int           k;
        bit           found;
        r = '0;
        r.last = 1'b1;
        found = 1'b0;
        case (f)
            FN_LOAD:
            begin
                if (table_fill >= TABLE_DEPTH)
                begin
                    r.status = ST_FULL;
                    full_drops++;
                end
                else
                begin
                    table_q[table_fill]    = q;
                    table_live[table_fill] = 1'b1;
                    r.status = ST_LOADED;
                    r.tag    = TAG_W'(table_fill);
                    r.q      = q;
                    table_fill++;
                end
                awaited_reports.push_back(r);
            end
            FN_SUB:
            begin
                r.status = ST_NOMATCH;
                for (int i = 0; i < table_fill && !found; i++)
                begin
                    if (table_live[i] && close_enough(q.x, table_q[i].x) &&
                        close_enough(q.y, table_q[i].y) && close_enough(q.z, table_q[i].z))
                    begin
                        table_live[i] = 1'b0;
                        r.status = ST_REMOVED;
                        r.tag    = TAG_W'(i);
                        r.q      = table_q[i];
                        found    = 1'b1;
                        removals++;
                    end
                end
                awaited_reports.push_back(r);
            end
            FN_READ:
            begin
                n_live = 0;
                for (int i = 0; i < table_fill; i++)
                    if (table_live[i])
                        n_live++;
                if (n_live == 0)
                begin
                    r.status = ST_NONE;
                    awaited_reports.push_back(r);
                end
                else
                begin
                    k = 0;
                    for (int i = 0; i < table_fill; i++)
                    begin
                        if (table_live[i])
                        begin
                            r.status = ST_SURVIVOR;
                            r.tag    = TAG_W'(i);
                            r.q      = table_q[i];
                            r.last   = (k == n_live - 1);
                            awaited_reports.push_back(r);
                            k++;
                        end
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    table_live[i] = 1'b0;
                table_fill = 0;
                r.status = ST_CLEARED;
                awaited_reports.push_back(r);
            end
        endcase
    endtask

    task automatic note_mismatch(input string what, input peak_result_t want,
                                 input peak_result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("MISMATCH %s: expected st=%0d tag=%0d q=(%0d,%0d,%0d) last=%0b",
                     what, want.status, want.tag, want.q.x, want.q.y, want.q.z, want.last);
            $display("    got st=%0d tag=%0d q=(%0d,%0d,%0d) last=%0b",
                     got.status, got.tag, got.q.x, got.q.y, got.q.z, got.last);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen_report.status = rsp_ch.status;
            seen_report.tag    = rsp_ch.tag;
            seen_report.q.x    = rsp_ch.out_x;
            seen_report.q.y    = rsp_ch.out_y;
            seen_report.q.z    = rsp_ch.out_z;
            seen_report.last   = rsp_ch.last;
            results_checked++;
            if (awaited_reports.size() == 0)
                note_mismatch("no result due", '0, seen_report);
            else if (awaited_reports[0].status !== seen_report.status ||
                     awaited_reports[0].tag    !== seen_report.tag ||
                     awaited_reports[0].q.x    !== seen_report.q.x ||
                     awaited_reports[0].q.y    !== seen_report.q.y ||
                     awaited_reports[0].q.z    !== seen_report.q.z ||
                     awaited_reports[0].last   !== seen_report.last)
                note_mismatch("field", awaited_reports[0], seen_report);
            if (awaited_reports.size() != 0)
                void'(awaited_reports.pop_front());
        end
    end

    // One request beat; valid stays high into the next call unless an idle gap is drawn
    task automatic send_peak_op(input logic [FUNC_W-1:0] f, input qvec_t q);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= f;
        req_ch.q_x   <= q.x;
        req_ch.q_y   <= q.y;
        req_ch.q_z   <= q.z;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_peak_op(f, q);
        items_sent++;
    endtask

    task automatic hold_requests();
        req_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (awaited_reports.size() != 0)
            @(posedge clk);
    endtask

    // Write only with the block idle: no request pending, every result returned
    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        hold_requests();
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        tol_now = value;
    endtask

    function automatic logic signed [Q_WIDTH-1:0] rand_q();
        case ($urandom_range(15))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            default: return Q_WIDTH'($urandom);
        endcase
    endfunction

    function automatic qvec_t random_peak();
        return peak(rand_q(), rand_q(), rand_q());
    endfunction

    // Move a component by up to the tolerance, or just past it now and then
    function automatic logic signed [Q_WIDTH-1:0] nudge(input logic signed [Q_WIDTH-1:0] v);
        longint d;
        if ($urandom_range(4) == 0)
            d = longint'(tol_now) + 1 + $urandom_range(3);
        else
            d = $urandom_range(tol_now);
        if ($urandom_range(1))
            d = -d;
        return Q_WIDTH'(longint'(v) + d);
    endfunction

    function automatic qvec_t near_peak();
        qvec_t q;
        if (table_fill == 0 || $urandom_range(3) == 0)
            return random_peak();
        q = table_q[$urandom_range(table_fill - 1)];
        return peak(nudge(q.x), nudge(q.y), nudge(q.z));
    endfunction

    // Episodes: optional clear, a run of loads, subtracts aimed at stored peaks, read-out
    task automatic run_peak_episodes(input int item_goal, input bit reach_full);
        int start_items;
        int n_load;
        int n_sub;
        start_items = items_sent;
        while (items_sent - start_items < item_goal)
        begin
            if ($urandom_range(3) != 0)
                send_peak_op(FN_CLEAR, random_peak());
            n_load = $urandom_range(1, 12);
            if (reach_full)
            begin
                n_load = TABLE_DEPTH - table_fill + 2;
                reach_full = 1'b0;
            end
            for (int i = 0; i < n_load; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_peak_op(FUNC_W'($urandom_range(3)), random_peak());
                else
                    send_peak_op(FN_LOAD, random_peak());
            end
            n_sub = $urandom_range(1, 12);
            for (int i = 0; i < n_sub; i++)
            begin
                if ($urandom_range(5) == 0)
                    send_peak_op(FN_READ, random_peak());
                else
                    send_peak_op(FN_SUB, near_peak());
            end
            send_peak_op(FN_READ, random_peak());
        end
    endtask

    // Reset tolerance of zero: exact matches only, ties, empty table cases
    task automatic test_basic_ops();
        send_peak_op(FN_READ, '0);
        send_peak_op(FN_SUB, '0);
        send_peak_op(FN_LOAD, peak(Q_MAX, Q_MAX, Q_MAX));
        send_peak_op(FN_LOAD, peak(Q_MIN, Q_MIN, Q_MIN));
        send_peak_op(FN_LOAD, '0);
        send_peak_op(FN_LOAD, '0);
        send_peak_op(FN_LOAD, peak(Q_WIDTH'(-1), Q_WIDTH'(1), Q_MIN));
        send_peak_op(FN_SUB, peak(Q_MIN, Q_MIN, Q_MIN));
        send_peak_op(FN_SUB, peak(Q_MIN, Q_MIN, Q_MIN));
        send_peak_op(FN_SUB, '0);
        send_peak_op(FN_SUB, peak('0, '0, Q_WIDTH'(1)));
        send_peak_op(FN_READ, '0);
    endtask

    // Widest and narrowest nonzero tolerance, clear and tag restart
    task automatic test_tolerance_edges();
        write_tolerance(TOL_MAX);
        send_peak_op(FN_SUB, '0);
        send_peak_op(FN_SUB, peak(Q_MAX, Q_MAX, Q_MAX));
        send_peak_op(FN_SUB, peak(Q_MAX, Q_MAX, Q_MAX));
        send_peak_op(FN_READ, '0);
        send_peak_op(FN_CLEAR, peak(Q_MAX, Q_MIN, Q_WIDTH'(-1)));
        send_peak_op(FN_READ, '0);
        write_tolerance(TOL_W'(1));
        send_peak_op(FN_LOAD, peak(Q_WIDTH'(5), Q_WIDTH'(5), Q_WIDTH'(5)));
        send_peak_op(FN_SUB, peak(Q_WIDTH'(6), Q_WIDTH'(4), Q_WIDTH'(5)));
        send_peak_op(FN_LOAD, peak(Q_WIDTH'(5), Q_WIDTH'(5), Q_WIDTH'(5)));
        send_peak_op(FN_SUB, peak(Q_WIDTH'(7), Q_WIDTH'(5), Q_WIDTH'(5)));
        send_peak_op(FN_READ, '0);
    endtask

    task automatic test_random_no_idle();
        write_tolerance('0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_peak_episodes(14, 1'b0);
    endtask

    task automatic test_random_sender_idle();
        write_tolerance(TOL_W'($urandom_range(1, 4096)));
        send_idle_pct  = 56;
        recv_stall_pct = 0;
        run_peak_episodes(14, 1'b0);
    endtask

    task automatic test_random_receiver_stall();
        write_tolerance(TOL_MAX);
        send_idle_pct  = 0;
        recv_stall_pct = 56;
        run_peak_episodes(14, 1'b0);
    endtask

    // Fill the table past its depth so loads are dropped and read-out is longest
    task automatic test_random_both_idle();
        write_tolerance(TOL_W'($urandom_range(16, 65535)));
        send_idle_pct  = 23;
        recv_stall_pct = 23;
        run_peak_episodes(38, 1'b1);
    endtask

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, awaited_reports.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.func  <= FN_LOAD;
        req_ch.q_x   <= '0;
        req_ch.q_y   <= '0;
        req_ch.q_z   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            table_q[i]    = '0;
            table_live[i] = 1'b0;
        end
        table_fill = 0;
        tol_now    = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_ops();
        test_tolerance_edges();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        hold_requests();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests sent, %0d results checked, %0d removals",
                 items_sent, results_checked, removals);
        $display("%0d drops on a full table; tolerance at zero, one, full scale and random",
                 full_drops);
        $display("four pacing mixes on both channels");
        if (mismatch_count == 0 && awaited_reports.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
